[rtl/ptzkb_pkg.sv]
// Package for the PTZ keyboard frame decoder: frame constants, result codes
// and the decoded-result struct shared by the decoder and top level.
// No dependencies.
package ptzkb_pkg;

  localparam int unsigned FRAME_CELLS = 5;   // frame bytes 2..6

  localparam logic [7:0] SYNC_BYTE     = 8'hff;
  localparam logic [7:0] CMD_SWITCH    = 8'h11;
  localparam logic [7:0] CMD_PTZ       = 8'h21;
  localparam logic [7:0] CMD_REGISTER  = 8'h41;
  localparam logic [7:0] ZOOM_IN_CODE  = 8'h40;
  localparam logic [7:0] ZOOM_OUT_CODE = 8'h80;
  localparam logic [6:0] STEP_MASK     = 7'h7f;

  // byte positions within a frame
  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_CMD   = 3'd2;
  localparam logic [2:0] POS_CSUM  = 3'd7;

  // message type codes
  localparam logic [1:0] MSG_SWITCH  = 2'd0;
  localparam logic [1:0] MSG_PTZ     = 2'd1;
  localparam logic [1:0] MSG_UNKNOWN = 2'd2;

  // ptz flag bit positions
  localparam int unsigned FLAG_STOP     = 0;
  localparam int unsigned FLAG_ZOOM_IN  = 1;
  localparam int unsigned FLAG_ZOOM_OUT = 2;
  localparam int unsigned FLAG_LEFT     = 3;
  localparam int unsigned FLAG_RIGHT    = 4;
  localparam int unsigned FLAG_UP       = 5;
  localparam int unsigned FLAG_DOWN     = 6;

  // cell 0 holds the newest byte (frame byte 6), cell 4 the command
  typedef logic [FRAME_CELLS-1:0][7:0] frame_t;

  typedef struct packed {
    logic [1:0] msg_type;
    logic [7:0] camera;
    logic [7:0] monitor;
    logic [6:0] pan_step;
    logic [6:0] tilt_step;
    logic [6:0] ptz_flags;
    logic       checksum_ok;
    logic       register_request;
    logic       deliver;
  } result_t;

endpackage

[rtl/ptz_keyboard_frame_decoder_core.sv]
// PTZ keyboard frame decoder: one received byte per word, one decoded command
// per 8-byte frame (sync 0xff, address, command, data 3..6, checksum).
// Throughput: one byte word per cycle, but for a stalled eighth byte. The result
// word is registered and valid in the cycle after the frame's eighth byte is accepted.
// A held result only stalls an eighth byte; other bytes keep flowing.
// Reset (rst_n low, synchronous): hunt for sync, clear sum, lock off, no result.
module ptz_keyboard_frame_decoder_core
  import ptzkb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // byte input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // configuration write channel (locked register)
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_locked,
  // decoded result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_msg_type,
  output logic [7:0] out_camera,
  output logic [7:0] out_monitor,
  output logic [6:0] out_pan_step,
  output logic [6:0] out_tilt_step,
  output logic [6:0] out_ptz_flags,
  output logic       out_checksum_ok,
  output logic       out_register_request,
  output logic       out_deliver
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [2:0] pos_r, pos_nxt;        // 0 hunting, 1..7 next frame byte
  logic [7:0] sum_r, sum_nxt;        // sum of frame bytes 1..6 mod 256
  logic       locked_r, locked_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r, res_nxt;

  logic       in_fire;
  logic       last_byte;
  logic       shift_en;
  frame_t     frame;
  result_t    dec_result;

  // An eighth byte needs a free output slot; every other byte is always taken.
  assign last_byte = (pos_r == POS_CSUM);
  assign in_ready  = !last_byte || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Shift frame bytes 2..6 into the cell chain.
  assign shift_en  = in_fire && (pos_r >= POS_CMD) && !last_byte;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Frame byte chain: cell 0 takes the new byte, each cell hands to the next
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < FRAME_CELLS; i++) begin : g_cell
    logic [7:0] cell_d;
    if (i == 0) begin : g_head
      assign cell_d = in_rx_byte;
    end else begin : g_link
      assign cell_d = frame[i-1];
    end
    ptzkb_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (cell_d),
      .q_out    (frame[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Decode on the checksum byte
  // ---------------------------------------------------------------------------
  ptzkb_decode u_decode (
    .frame     (frame),
    .sum       (sum_r),
    .csum_byte (in_rx_byte),
    .locked    (locked_r),
    .result    (dec_result)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    locked_nxt    = locked_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    if (cfg_valid && cfg_ready) begin
      locked_nxt = cfg_locked;
    end

    // drop the held result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      if (pos_r == POS_HUNT) begin
        // hunt: only the sync byte opens a frame
        if (in_rx_byte == SYNC_BYTE) begin
          pos_nxt = POS_FIRST;
          sum_nxt = 8'd0;
        end
      end else if (last_byte) begin
        // checksum byte: emit and go back to hunting
        pos_nxt       = POS_HUNT;
        res_nxt       = dec_result;
        out_valid_nxt = 1'b1;
      end else begin
        // bytes 1..6 (a 0xff here is plain data)
        sum_nxt = sum_r + in_rx_byte;
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      sum_r       <= 8'd0;
      locked_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      locked_r    <= locked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload carries no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_valid            = out_valid_r;
  assign out_msg_type         = res_r.msg_type;
  assign out_camera           = res_r.camera;
  assign out_monitor          = res_r.monitor;
  assign out_pan_step         = res_r.pan_step;
  assign out_tilt_step        = res_r.tilt_step;
  assign out_ptz_flags        = res_r.ptz_flags;
  assign out_checksum_ok      = res_r.checksum_ok;
  assign out_register_request = res_r.register_request;
  assign out_deliver          = res_r.deliver;

endmodule

[rtl/ptzkb_cell.sv]
// One byte cell of the frame shift chain: takes its neighbor's byte on shift.
// Depends on nothing.
module ptzkb_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d_in,
  output logic [7:0] q_out
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q_out = byte_r;

endmodule

[rtl/ptzkb_decode.sv]
// Command decoder: turns the collected frame bytes, running sum and checksum
// byte into one result. Depends on ptzkb_pkg.
module ptzkb_decode
  import ptzkb_pkg::*;
(
  input  frame_t      frame,
  input  logic [7:0]  sum,
  input  logic [7:0]  csum_byte,
  input  logic        locked,
  output result_t     result
);

  logic [7:0] cmd, b3, b4, b5, b6;
  logic [6:0] pan, tilt;

  assign cmd = frame[4];
  assign b3  = frame[3];
  assign b4  = frame[2];
  assign b5  = frame[1];
  assign b6  = frame[0];
  assign pan  = b5[6:0] & STEP_MASK;
  assign tilt = b6[6:0] & STEP_MASK;

  always_comb begin
    result = '0;
    result.msg_type         = MSG_UNKNOWN;
    result.camera           = b4;
    result.checksum_ok      = (sum == csum_byte);
    result.register_request = (cmd == CMD_REGISTER);
    result.deliver          = ~locked;
    unique case (cmd)
      CMD_SWITCH: begin
        result.msg_type = MSG_SWITCH;
        result.monitor  = b5;
      end
      CMD_PTZ: begin
        result.msg_type  = MSG_PTZ;
        result.pan_step  = pan;
        result.tilt_step = tilt;
        result.ptz_flags[FLAG_STOP]     = (b3 == 8'd0) && (b5 == 8'd0) && (b6 == 8'd0);
        result.ptz_flags[FLAG_ZOOM_IN]  = (b3 == ZOOM_IN_CODE);
        result.ptz_flags[FLAG_ZOOM_OUT] = (b3 == ZOOM_OUT_CODE);
        result.ptz_flags[FLAG_LEFT]     = (pan != 7'd0) && !b5[7];
        result.ptz_flags[FLAG_RIGHT]    = (pan != 7'd0) && b5[7];
        result.ptz_flags[FLAG_UP]       = (tilt != 7'd0) && !b6[7];
        result.ptz_flags[FLAG_DOWN]     = (tilt != 7'd0) && b6[7];
      end
      default: begin
        result.msg_type = MSG_UNKNOWN;
      end
    endcase
  end

endmodule

[rtl/ptzkb_checker.sv]
// Port-level checker for the PTZ keyboard frame decoder, bound to the top level.
// Depends on ptzkb_pkg and ptz_keyboard_frame_decoder_core.
module ptzkb_checker
  import ptzkb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_msg_type,
  input logic [7:0] out_monitor,
  input logic [6:0] out_pan_step,
  input logic [6:0] out_tilt_step,
  input logic [6:0] out_ptz_flags,
  input logic       out_register_request
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_msg_type)
      && $stable(out_ptz_flags) && $stable(out_monitor))
    else $error("result word changed while stalled");

  // motion fields only on ptz commands
  a_non_ptz_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_type != MSG_PTZ |->
      out_pan_step == 7'd0 && out_tilt_step == 7'd0 && out_ptz_flags == 7'd0)
    else $error("motion fields set on a non-ptz command");

  // stop excludes any direction, and a stopped ptz has no pan speed
  a_stop_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ptz_flags[FLAG_STOP] |->
      out_ptz_flags[FLAG_DOWN:FLAG_LEFT] == 4'd0 && out_pan_step == 7'd0)
    else $error("stop flag with motion");

  // direction flags follow the step values
  a_dir_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_type == MSG_PTZ |->
      ((out_pan_step != 7'd0) == (out_ptz_flags[FLAG_LEFT] || out_ptz_flags[FLAG_RIGHT]))
      && ((out_tilt_step != 7'd0) == (out_ptz_flags[FLAG_UP] || out_ptz_flags[FLAG_DOWN])))
    else $error("direction flags disagree with steps");

  // a register request is never a switch or ptz command
  a_reg_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_register_request |-> out_msg_type == MSG_UNKNOWN)
    else $error("register request with known command type");

endmodule

bind ptz_keyboard_frame_decoder_core ptzkb_checker u_ptzkb_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_msg_type         (out_msg_type),
  .out_monitor          (out_monitor),
  .out_pan_step         (out_pan_step),
  .out_tilt_step        (out_tilt_step),
  .out_ptz_flags        (out_ptz_flags),
  .out_register_request (out_register_request)
);

[tb/testbench.sv]
// Self-checking testbench for ptz_keyboard_frame_decoder_core: random and directed byte
// streams with random stalls on both sides, checked against an in-bench frame decoder.
// Depends on ptzkb_pkg and the core RTL only.
module testbench;
  import ptzkb_pkg::*;

  // Track frame position, sum and lock state, and queue the decoded word that each
  // checksum byte should produce.
  class frame_scoreboard;
    logic [2:0] pos;
    logic [7:0] held[FRAME_CELLS];   // frame bytes 2..6, command first
    logic [7:0] sum;
    logic       locked;
    result_t    expected_q[$];
    int         errors;

    function new();
      pos = POS_HUNT;
      sum = 8'h00;
      locked = 1'b0;
      foreach (held[i]) held[i] = 8'h00;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_locked(logic v);
      locked = v;
    endfunction

    function result_t decode_frame(logic [7:0] csum);
      result_t    r;
      logic [7:0] cmd, b3, b4, b5, b6;
      cmd = held[0];
      b3 = held[1];
      b4 = held[2];
      b5 = held[3];
      b6 = held[4];
      r = '0;
      r.camera = b4;
      r.checksum_ok = (sum == csum);
      r.register_request = (cmd == CMD_REGISTER);
      r.deliver = !locked;
      if (cmd == CMD_SWITCH) begin
        r.msg_type = MSG_SWITCH;
        r.monitor = b5;
      end else if (cmd == CMD_PTZ) begin
        r.msg_type = MSG_PTZ;
        r.pan_step = b5[6:0] & STEP_MASK;
        r.tilt_step = b6[6:0] & STEP_MASK;
        r.ptz_flags[FLAG_STOP] = (b3 == 8'h00 && b5 == 8'h00 && b6 == 8'h00);
        r.ptz_flags[FLAG_ZOOM_IN] = (b3 == ZOOM_IN_CODE);
        r.ptz_flags[FLAG_ZOOM_OUT] = (b3 == ZOOM_OUT_CODE);
        if (r.pan_step != 7'd0) r.ptz_flags[b5[7] ? FLAG_RIGHT : FLAG_LEFT] = 1'b1;
        if (r.tilt_step != 7'd0) r.ptz_flags[b6[7] ? FLAG_DOWN : FLAG_UP] = 1'b1;
      end else begin
        r.msg_type = MSG_UNKNOWN;
      end
      return r;
    endfunction

    // Advance the frame state by one accepted byte word.
    function void note_byte(logic [7:0] b);
      if (pos == POS_HUNT) begin
        if (b == SYNC_BYTE) begin
          pos = POS_FIRST;
          sum = 8'h00;
        end
      end else if (pos != POS_CSUM) begin
        if (pos >= POS_CMD) held[pos - POS_CMD] = b;
        sum = sum + b;
        pos = pos + 3'd1;
      end else begin
        pos = POS_HUNT;
        expected_q.push_back(decode_frame(b));
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result word with no completed frame");
        return;
      end
      want = expected_q.pop_front();
      check_field("msg_type", 8'(got.msg_type), 8'(want.msg_type));
      check_field("camera", got.camera, want.camera);
      check_field("monitor", got.monitor, want.monitor);
      check_field("pan_step", 8'(got.pan_step), 8'(want.pan_step));
      check_field("tilt_step", 8'(got.tilt_step), 8'(want.tilt_step));
      check_field("ptz_flags", 8'(got.ptz_flags), 8'(want.ptz_flags));
      check_field("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
      check_field("register_request", 8'(got.register_request),
                  8'(want.register_request));
      check_field("deliver", 8'(got.deliver), 8'(want.deliver));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_locked = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_msg_type;
  logic [7:0] out_camera;
  logic [7:0] out_monitor;
  logic [6:0] out_pan_step;
  logic [6:0] out_tilt_step;
  logic [6:0] out_ptz_flags;
  logic       out_checksum_ok;
  logic       out_register_request;
  logic       out_deliver;

  result_t    seen;
  frame_scoreboard sb = new();

  logic [7:0] plan_q[$];          // byte words waiting to be offered
  int         in_gap_pct = 31;    // chance of an idle before each byte word
  int         out_gap_pct = 31;   // chance of out_ready low on a cycle
  int         hold_request = 0;   // cycles for the receiver to hold off

  ptz_keyboard_frame_decoder_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_locked           (cfg_locked),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_msg_type         (out_msg_type),
    .out_camera           (out_camera),
    .out_monitor          (out_monitor),
    .out_pan_step         (out_pan_step),
    .out_tilt_step        (out_tilt_step),
    .out_ptz_flags        (out_ptz_flags),
    .out_checksum_ok      (out_checksum_ok),
    .out_register_request (out_register_request),
    .out_deliver          (out_deliver)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pack the result ports in the same order as the package struct.
  assign seen = {out_msg_type, out_camera, out_monitor, out_pan_step, out_tilt_step,
                 out_ptz_flags, out_checksum_ok, out_register_request, out_deliver};

  // Sample both handshakes at the edge, before any of this edge's updates land.
  // The result is registered, so a word checked here never belongs to
  // the byte accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(seen);
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
    end
  end

  // Receiver: random backpressure, plus a long hold-off on request. The hold
  // is counted here so the sender keeps offering bytes meanwhile.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  // Offer one byte word; hold valid and data until it is taken.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain the plan, then drop valid so nothing more is taken.
  task automatic send_plan();
    while (plan_q.size() != 0) send_byte(plan_q.pop_front());
    in_valid <= 1'b0;
  endtask

  task automatic write_locked(input logic v);
    cfg_valid <= 1'b1;
    cfg_locked <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_locked(v);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every outstanding word, then give the result register time to settle.
  task automatic wait_results(input int limit);
    int n;
    n = 0;
    while (sb.pending() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Queue a whole frame; flip one checksum bit when a bad sum is wanted.
  function automatic void push_frame(input logic [7:0] addr, cmd, b3, b4, b5, b6,
                                     input bit bad_sum);
    logic [7:0] csum;
    csum = addr + cmd + b3 + b4 + b5 + b6;
    if (bad_sum) csum = csum ^ (8'h01 << $urandom_range(7));
    plan_q.push_back(SYNC_BYTE);
    plan_q.push_back(addr);
    plan_q.push_back(cmd);
    plan_q.push_back(b3);
    plan_q.push_back(b4);
    plan_q.push_back(b5);
    plan_q.push_back(b6);
    plan_q.push_back(csum);
  endfunction

  // Speed byte biased toward zero steps and bare direction bits.
  function automatic logic [7:0] pick_step();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one random frame, now and then preceded by line noise or replaced by a
  // cut-off frame. Return the count of frame bytes queued (noise excluded).
  function automatic int push_random_frame();
    logic [7:0] cmd, b3, b5, b6;
    int         pick, cut;
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(3, 1)) plan_q.push_back(8'($urandom_range(254)));
    if ($urandom_range(99) < 6) begin
      cut = $urandom_range(6);
      plan_q.push_back(SYNC_BYTE);
      repeat (cut) plan_q.push_back(8'($urandom));
      return cut + 1;
    end
    pick = $urandom_range(99);
    b3 = 8'($urandom);
    b5 = 8'($urandom);
    b6 = 8'($urandom);
    if (pick < 35) begin
      cmd = CMD_PTZ;
      case ($urandom_range(3))
        0: b3 = 8'h00;
        1: b3 = ZOOM_IN_CODE;
        2: b3 = ZOOM_OUT_CODE;
        default: ;
      endcase
      b5 = pick_step();
      b6 = pick_step();
      // force a stop frame now and then
      if ($urandom_range(99) < 15) begin
        b3 = 8'h00;
        b5 = 8'h00;
        b6 = 8'h00;
      end
    end else if (pick < 60) begin
      cmd = CMD_SWITCH;
    end else if (pick < 72) begin
      cmd = CMD_REGISTER;
    end else begin
      cmd = 8'($urandom);
    end
    push_frame(8'($urandom), cmd, b3, 8'($urandom), b5, b6, $urandom_range(99) < 20);
    return 8;
  endfunction

  // Random frames up to a byte budget; optionally stop halfway until all results are in.
  task automatic run_random(input int budget, input bit pause_midway);
    int sent;
    sent = 0;
    while (sent < budget) begin
      sent += push_random_frame();
      if (pause_midway && sent >= budget / 2) begin
        send_plan();
        wait_results(2000);
        pause_midway = 1'b0;
      end
    end
    send_plan();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise while hunting, a PTZ frame whose address byte equals sync,
    // a switch frame with a bad checksum, and a register request.
    write_locked(1'b0);
    plan_q.push_back(8'h00);
    push_frame(SYNC_BYTE, CMD_PTZ, ZOOM_IN_CODE, 8'hff, 8'h81, 8'h7f, 1'b0);
    push_frame(8'h00, CMD_SWITCH, ZOOM_OUT_CODE, 8'h00, 8'hff, 8'h00, 1'b1);
    push_frame(8'h80, CMD_REGISTER, 8'h00, 8'h55, 8'h00, 8'hff, 1'b0);
    send_plan();
    wait_results(2000);

    // Locked, with a long receiver hold-off so the core fills and stalls input.
    write_locked(1'b1);
    hold_request = 250;
    run_random(300, 1'b0);
    wait_results(2000);

    // Unlocked, no idling on either side.
    write_locked(1'b0);
    in_gap_pct = 0;
    out_gap_pct = 0;
    run_random(300, 1'b0);
    wait_results(2000);

    // Locked again; the sender pauses midway until every result is back.
    in_gap_pct = 31;
    out_gap_pct = 31;
    write_locked(1'b1);
    run_random(300, 1'b1);
    wait_results(2000);

    write_locked(1'b0);
    run_random(350, 1'b0);
    wait_results(5000);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d decoded words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/ptzkb_pkg.sv
rtl/ptzkb_cell.sv
rtl/ptzkb_decode.sv
rtl/ptz_keyboard_frame_decoder_core.sv
rtl/ptzkb_checker.sv
tb/testbench.sv
